// ----- rtl/ratapx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratapx_pkg
// Shared constants for the rational approximation block: default widths,
// register map and register reset values.
// ----------------------------------------------------------------------------
package ratapx_pkg;

  localparam int FRACTION_BITS_DEF = 32;
  localparam int INTEGER_BITS_DEF  = 16;
  localparam int DEN_BITS_DEF      = 12;

  // tolerance register width and the binary point it is expressed against
  localparam int TOL_BITS       = 16;
  localparam int TOL_SCALE_BITS = 32;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_DEN = 1'b0;
  localparam logic REG_TOL     = 1'b1;

  localparam int MAX_DEN_RESET = 1000;
  localparam int TOL_RESET     = 4295;

endpackage

// ----- rtl/ratapx_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratapx_regs
// APB register file: maximum denominator and tolerance, with readback.
// ----------------------------------------------------------------------------
module ratapx_regs
  import ratapx_pkg::*;
#(
  parameter int DEN_BITS = DEN_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [DEN_BITS-1:0]      max_den,
  output logic [TOL_BITS-1:0]      tol
);

  localparam int DEN_MAX     = (1 << DEN_BITS) - 1;
  localparam int MAX_DEN_RST = (MAX_DEN_RESET > DEN_MAX) ? DEN_MAX : MAX_DEN_RESET;

  logic [DEN_BITS-1:0] max_den_r;
  logic [TOL_BITS-1:0] tol_r;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_den_r <= DEN_BITS'(MAX_DEN_RST);
      tol_r     <= TOL_BITS'(TOL_RESET);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_DEN: max_den_r <= pwdata[DEN_BITS-1:0];
        REG_TOL:     tol_r     <= pwdata[TOL_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_DEN: prdata = APB_DATA_BITS'(max_den_r);
      REG_TOL:     prdata = APB_DATA_BITS'(tol_r);
      default:     prdata = '0;
    endcase
  end

  assign max_den = max_den_r;
  assign tol     = tol_r;

endmodule

// ----- rtl/rational_approximation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_approximation
// Best rational approximation of a signed fixed-point value by a walk of the
// Stern-Brocot mediant tree.
// ----------------------------------------------------------------------------
// The block takes one value at a time and returns numerator/denominator with
// the floored integer part folded into the numerator. A value with a zero
// fraction goes from acceptance straight to S_OUT. Otherwise every tree step
// forms the mediant in S_MED, then compares it against the fraction in S_CMP,
// and a walk takes up to max_denominator steps for fractions near 0 or 1. The
// walk ends in S_MED when a bound denominator exceeds max_denominator, or in
// S_CMP when the mediant lies within the tolerance; S_FIN then picks the
// result and S_OUT waits while the output is stalled. Products of the
// fraction and the tolerance with the bound denominators are kept as running
// sums, so the search needs no multiplier; the final numerator uses one small
// multiply. A new value is accepted the cycle after the previous result is
// handed to the output register.
// ----------------------------------------------------------------------------
module rational_approximation
  import ratapx_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = INTEGER_BITS_DEF,
  parameter int DEN_BITS      = DEN_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [INTEGER_BITS+FRACTION_BITS-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [INTEGER_BITS+DEN_BITS-1:0] out_numerator,
  output logic        [DEN_BITS-1:0]            out_denominator,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [APB_ADDR_BITS-1:0]       paddr,
  input  logic        [APB_DATA_BITS-1:0]       pwdata,
  output logic        [APB_DATA_BITS-1:0]       prdata,
  output logic                                  pready
);

  localparam int FB = FRACTION_BITS;
  localparam int IB = INTEGER_BITS;
  localparam int BW = DEN_BITS + 1;            // bound / mediant denominators
  localparam int PW = FB + BW;                 // fraction * denominator
  localparam int LW = TOL_BITS + BW;           // tolerance * denominator
  localparam int NW = IB + DEN_BITS;           // result numerator
  localparam int CW = ((FB > TOL_SCALE_BITS) ? FB : TOL_SCALE_BITS) + BW;
  localparam int SH_D = (FB < TOL_SCALE_BITS) ? TOL_SCALE_BITS - FB : 0;
  localparam int SH_L = (FB >= TOL_SCALE_BITS) ? FB - TOL_SCALE_BITS : 0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MED  = 5'b00010,
    S_CMP  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  logic [DEN_BITS-1:0] max_den;
  logic [TOL_BITS-1:0] tol;

  ratapx_regs #(
    .DEN_BITS (DEN_BITS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_den (max_den),
    .tol     (tol)
  );

  state_t                 state_r;
  logic [FB-1:0]          frac_r;
  logic signed [IB-1:0]   ip_r;
  logic [BW-1:0]          ln_r, ld_r, hn_r, hd_r;
  logic [PW-1:0]          pl_r, ph_r;
  logic [LW-1:0]          tl_r, th_r;
  logic [BW-1:0]          mn_r, md_r;
  logic [PW-1:0]          pm_r;
  logic [LW-1:0]          lm_r;
  logic [DEN_BITS-1:0]    res_n_r, res_d_r;
  logic                   out_valid_r;
  logic [NW-1:0]          out_num_r;
  logic [DEN_BITS-1:0]    out_den_r;

  logic                   in_acc;
  logic                   out_free;
  logic [FB-1:0]          in_frac;
  logic [PW-1:0]          mn_sh;
  logic                   gt;
  logic [PW-1:0]          diff;
  logic [CW-1:0]          diff_cmp, lim_cmp;
  logic                   close;
  logic                   bound_over;
  logic [BW-1:0]          den_sum;
  logic signed [NW:0]     prod;
  logic [NW:0]            num_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_frac   = in_value[FB-1:0];

  // mediant against fraction: sign of f*md - mn*2^FB and its distance
  assign mn_sh    = {mn_r[DEN_BITS:0], {FB{1'b0}}};
  assign gt       = pm_r > mn_sh;
  assign diff     = gt ? (pm_r - mn_sh) : (mn_sh - pm_r);
  assign diff_cmp = CW'(diff) << SH_D;
  assign lim_cmp  = CW'(lm_r) << SH_L;
  assign close    = diff_cmp < lim_cmp;

  assign bound_over = (ld_r > BW'(max_den)) | (hd_r > BW'(max_den));
  assign den_sum    = ld_r + hd_r;

  assign prod    = ip_r * $signed({1'b0, res_d_r});
  assign num_sum = prod + (NW+1)'(res_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (in_frac == '0) ? S_OUT : S_MED;
          end
        end
        S_MED: begin
          state_r <= bound_over ? S_FIN : S_CMP;
        end
        S_CMP: begin
          state_r <= close ? S_FIN : S_MED;
        end
        S_FIN: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          frac_r  <= in_frac;
          ip_r    <= in_value[IB+FB-1:FB];
          ln_r    <= '0;
          ld_r    <= BW'(1);
          hn_r    <= BW'(1);
          hd_r    <= BW'(1);
          pl_r    <= PW'(in_frac);
          ph_r    <= PW'(in_frac);
          tl_r    <= LW'(tol);
          th_r    <= LW'(tol);
          res_n_r <= '0;
          res_d_r <= DEN_BITS'(1);
        end
      end
      S_MED: begin
        mn_r <= ln_r + hn_r;
        md_r <= den_sum;
        pm_r <= pl_r + ph_r;
        lm_r <= tl_r + th_r;
      end
      S_CMP: begin
        if (!close) begin
          if (gt) begin
            ln_r <= mn_r;
            ld_r <= md_r;
            pl_r <= pm_r;
            tl_r <= lm_r;
          end else begin
            hn_r <= mn_r;
            hd_r <= md_r;
            ph_r <= pm_r;
            th_r <= lm_r;
          end
        end
      end
      S_FIN: begin
        if (den_sum <= BW'(max_den)) begin
          res_n_r <= DEN_BITS'(ln_r + hn_r);
          res_d_r <= DEN_BITS'(den_sum);
        end else if (hd_r < ld_r) begin
          res_n_r <= DEN_BITS'(hn_r);
          res_d_r <= DEN_BITS'(hd_r);
        end else begin
          res_n_r <= DEN_BITS'(ln_r);
          res_d_r <= DEN_BITS'(ld_r);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_num_r <= num_sum[NW-1:0];
          out_den_r <= res_d_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;

endmodule
